>>> rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg: shared types and constants for the priority task dispatcher
// Table size, field widths, function and status codes, the word that walks
// the cell chain, and the controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int TASKS      = 16;
  localparam int TIME_BITS  = 32;
  localparam int PRIO_BITS  = 8;
  localparam int IDX_W      = (TASKS > 1) ? $clog2(TASKS) : 1;

  // fixed port field widths
  localparam int FUNC_W     = 2;
  localparam int TIME_IN_W  = 32;
  localparam int PRIO_IN_W  = 8;
  localparam int SLOT_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int SLOT_CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 2'd0,
    FN_DELETE = 2'd1,
    FN_PICK   = 2'd2,
    FN_DONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NONE_DUE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  // request word handed from cell to cell, with the running result
  typedef struct packed {
    func_t                func;
    logic [TIME_BITS-1:0] now_time;
    logic [TIME_BITS-1:0] first_run;
    logic [TIME_BITS-1:0] period;
    logic [PRIO_BITS-1:0] prio;
    logic [SLOT_W-1:0]    slot;
    logic                 hit;
    logic [PRIO_BITS-1:0] best;
    logic [IDX_W-1:0]     res_slot;
  } tok_t;

endpackage

>>> rtl/priority_task_dispatcher.sv
// ----------------------------------------------------------------------------
// priority_task_dispatcher: periodic task table with priority pick
// Each request word walks a row of TASKS cells, one slot per cell and one
// cell per cycle. The result word of every request (add, delete, pick, done)
// is registered at the tail of the cell chain and held until taken. One
// request is in flight at a time: the input is ready again once the result
// word has been taken. Add fills the lowest free slot or answers table full;
// delete clears a slot; pick returns the highest-priority task due strictly
// before now_time, lowest slot on a tie, or none due; done reschedules a slot
// to now_time plus its period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_task_dispatcher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // func[1:0], now_time[33:2], first_run[65:34], period[97:66],
  // priority_req[105:98], slot[109:106], zero[111:110]
  input  logic [ptd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // slot_out[3:0], status[5:4], zero[7:6]
  output logic [ptd_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ptd_pkg::*;

  state_t              state_r, state_nxt;
  logic                in_acc;
  logic                act   [TASKS+1];
  tok_t                tok   [TASKS+1];
  tok_t                tok_head;
  logic [SLOT_W-1:0]   slot_out_r, slot_out_nxt;
  status_t             status_r, status_nxt;

  assign in_acc = in_tvalid && in_tready;

  // request word entering the chain
  always_comb begin
    tok_head.func      = func_t'(in_tdata[1:0]);
    tok_head.now_time  = TIME_BITS'(in_tdata[33:2]);
    tok_head.first_run = TIME_BITS'(in_tdata[65:34]);
    tok_head.period    = TIME_BITS'(in_tdata[97:66]);
    tok_head.prio      = PRIO_BITS'(in_tdata[105:98]);
    tok_head.slot      = in_tdata[109:106];
    tok_head.hit       = 1'b0;
    tok_head.best      = '0;
    tok_head.res_slot  = '0;
  end

  assign act[0] = in_acc;
  assign tok[0] = tok_head;

  for (genvar i = 0; i < TASKS; i++) begin : g_cell
    ptd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .act_in   (act[i]),
      .tok_in   (tok[i]),
      .act_out  (act[i+1]),
      .tok_out  (tok[i+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_RUN;
      S_RUN:   if (act[TASKS]) state_nxt = S_HOLD;
      S_HOLD:  if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready  = 1'b1;
      S_HOLD:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  // result from the tail of the chain
  always_comb begin
    slot_out_nxt = slot_out_r;
    status_nxt   = status_r;
    if (act[TASKS]) begin
      slot_out_nxt = tok[TASKS].hit ? SLOT_W'(tok[TASKS].res_slot) : '0;
      status_nxt   = ST_OK;
      if (!tok[TASKS].hit) begin
        if (tok[TASKS].func == FN_ADD)  status_nxt = ST_FULL;
        if (tok[TASKS].func == FN_PICK) status_nxt = ST_NONE_DUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_out_r <= slot_out_nxt;
    status_r   <= status_nxt;
  end

  assign out_tdata = {2'b00, status_r, slot_out_r};

`ifndef SYNTHESIS
  a_tail_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    act[TASKS] |-> state_r == S_RUN)
    else $error("word left the chain outside a run");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while a result is pending");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> act[1] && state_r == S_RUN)
    else $error("accepted word did not enter the chain");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (status_r == ST_OK || status_r == ST_NONE_DUE ||
                    status_r == ST_FULL))
    else $error("bad status code");
`endif

endmodule

>>> rtl/ptd_cell.sv
// ----------------------------------------------------------------------------
// ptd_cell: one table slot of the dispatcher
// Holds one task and acts on the request word passing through, then hands
// the updated word, registered, to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptd_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ptd_pkg::IDX_W-1:0] cell_idx,
  input  logic                  act_in,
  input  ptd_pkg::tok_t         tok_in,
  output logic                  act_out,
  output ptd_pkg::tok_t         tok_out
);
  import ptd_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] next_run_r, next_run_nxt;
  logic [TIME_BITS-1:0] period_r, period_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                 act_r;
  tok_t                 tok_r, tok_nxt;
  logic                 match;
  logic                 due;

  assign match = (SLOT_CMP_W'(tok_in.slot) == SLOT_CMP_W'(cell_idx));
  assign due   = valid_r && (next_run_r < tok_in.now_time);

  always_comb begin
    valid_nxt    = valid_r;
    next_run_nxt = next_run_r;
    period_nxt   = period_r;
    prio_nxt     = prio_r;
    tok_nxt      = tok_in;
    if (act_in) begin
      unique case (tok_in.func)
        FN_ADD: begin
          // lowest free slot wins: first free cell the word meets
          if (!valid_r && !tok_in.hit) begin
            valid_nxt        = 1'b1;
            next_run_nxt     = tok_in.first_run;
            period_nxt       = tok_in.period;
            prio_nxt         = tok_in.prio;
            tok_nxt.hit      = 1'b1;
            tok_nxt.res_slot = cell_idx;
          end
        end
        FN_DELETE: begin
          if (match) valid_nxt = 1'b0;
        end
        FN_PICK: begin
          // strict > keeps the lower slot on a tie
          if (due && (!tok_in.hit || prio_r > tok_in.best)) begin
            tok_nxt.hit      = 1'b1;
            tok_nxt.best     = prio_r;
            tok_nxt.res_slot = cell_idx;
          end
        end
        FN_DONE: begin
          if (match && valid_r) next_run_nxt = tok_in.now_time + period_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      act_r   <= act_in;
    end
  end

  always_ff @(posedge clk) begin
    next_run_r <= next_run_nxt;
    period_r   <= period_nxt;
    prio_r     <= prio_nxt;
    tok_r      <= tok_nxt;
  end

  assign act_out = act_r;
  assign tok_out = tok_r;

endmodule
